FILE: sv/iiea_pkg.sv
// Shared types and constants for the indexed insert/erase array.
// Holds the operation and status codes and the command broadcast to the cells.
// No dependencies.
package iiea_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_W        = 32;
  localparam int INDEX_W       = 5;
  localparam int COUNT_FIELD_W = 5;
  localparam int OP_W          = 2;
  localparam int ST_W          = 2;
  // Wide enough for the position of any cell up to the largest capacity.
  localparam int CELL_IDX_W    = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd3;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    logic               ins;
    logic               ers;
    logic [INDEX_W-1:0] pos;
  } cmd_t;

endpackage

FILE: sv/iiea_cell.sv
// One storage cell of the indexed insert/erase array.
// Depends on iiea_pkg for the command type and word width.
module iiea_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  iiea_pkg::cmd_t              cmd,
  input  logic [iiea_pkg::WORD_W-1:0] lower,
  input  logic [iiea_pkg::WORD_W-1:0] upper,
  input  logic [iiea_pkg::WORD_W-1:0] word,
  output logic [iiea_pkg::WORD_W-1:0] entry
);
  import iiea_pkg::*;

  localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

  logic [CELL_IDX_W-1:0] pos_ext;
  logic                  at_pos;
  logic                  above_pos;
  logic [WORD_W-1:0]     entry_next;

  assign pos_ext   = CELL_IDX_W'(cmd.pos);
  assign at_pos    = (MY_IDX == pos_ext);
  assign above_pos = (MY_IDX > pos_ext);

  always_comb begin
    entry_next = entry;
    if (cmd.ins) begin
      if (above_pos) begin
        entry_next = lower;
      end else if (at_pos) begin
        entry_next = word;
      end
    end else if (cmd.ers) begin
      if (above_pos || at_pos) begin
        entry_next = upper;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

FILE: sv/indexed_insert_erase_array.sv
// Top level of the indexed insert/erase array: a row of cells and the list control.
// Depends on iiea_pkg and iiea_cell.
//
// Channel  Dir  Contents (lowest bit first)
// s        in   tdata: index[4:0], value[36:5]; tuser: op[1:0]
// m        out  tdata: read_value[31:0], element_count[36:32]; tuser: status[1:0]
//
// Each word is handled as follows: every cell loads its next entry from a
// neighbour, from the input word or from itself on the edge at which the word is
// accepted, and the result is registered for the output in the same edge.
// The read path is a selector over the cells, so the cell row sets the cycle time.
// Reset clears every entry and the count at once; no clearing pass is needed.
// A stalled result holds in the output register, and a new input word is taken
// in the cycle in which the waiting result leaves.
module indexed_insert_erase_array #(
  parameter int CAPACITY = iiea_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // index[4:0], value[36:5], zero fill above
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_value[31:0], element_count[36:32], zero fill
  output logic [1:0]  m_tuser    // status[1:0]
);
  import iiea_pkg::*;

  // The count must hold the capacity itself; comparisons run at a width that also
  // holds any index the input can carry.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int AW    = $clog2(CAPACITY);
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [OP_W-1:0]    in_op;
  logic [INDEX_W-1:0] in_index;
  logic [WORD_W-1:0]  in_value;
  logic               s_acc;

  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CMP_W-1:0]   count_ext;
  logic [CMP_W-1:0]   pos_ext;
  logic [ST_W-1:0]    status_next;
  logic [WORD_W-1:0]  rd_next;
  logic               do_ins;
  logic               do_ers;
  cmd_t               cmd;

  logic [WORD_W-1:0]  entries [CAPACITY];

  logic [WORD_W-1:0]        out_value;
  logic [COUNT_FIELD_W-1:0] out_count;
  logic [ST_W-1:0]          out_status;

  assign in_op    = s_tuser;
  assign in_index = s_tdata[4:0];
  assign in_value = s_tdata[36:5];

  // The output register frees up whenever its word is taken.
  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(in_index);

  // Decide the status and whether the row shifts. A full list outranks a bad
  // index on insert, and an empty list outranks it on erase. The unused
  // operation code changes nothing and reports success.
  always_comb begin
    status_next = ST_OK;
    do_ins      = 1'b0;
    do_ers      = 1'b0;
    rd_next     = '0;
    unique case (in_op)
      OP_INSERT: begin
        if (count_ext == CAP_C) begin
          status_next = ST_FULL;
        end else if (pos_ext > count_ext) begin
          status_next = ST_BAD_INDEX;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_ERASE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_ext >= count_ext) begin
          status_next = ST_BAD_INDEX;
        end else begin
          do_ers = 1'b1;
        end
      end
      OP_READ: begin
        // The count never exceeds the capacity, so an index below the count
        // always addresses a real cell.
        if (pos_ext >= count_ext) begin
          status_next = ST_BAD_INDEX;
        end else begin
          rd_next = entries[pos_ext[AW-1:0]];
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CNT_W'(1);
    end else if (do_ers) begin
      count_next = count - CNT_W'(1);
    end
  end

  assign cmd.ins = s_acc && do_ins;
  assign cmd.ers = s_acc && do_ers;
  assign cmd.pos = in_index;

  // The row of cells. Slots at and above the count always hold zero, so the word
  // shifted out of the top cell on insert is zero, and erase pulls zero into the
  // freed slot from the cell above it (or from the constant beyond the top cell).
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] lower;
    logic [WORD_W-1:0] upper;
    if (i == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = entries[i+1];
    end
    iiea_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .lower(lower),
      .upper(upper),
      .word (in_value),
      .entry(entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_acc) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload; the count field reports the low bits of the count only.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      out_value  <= rd_next;
      out_count  <= COUNT_FIELD_W'(CMP_W'(count_next));
      out_status <= status_next;
    end
  end

  assign m_tdata = {3'b000, out_count, out_value};
  assign m_tuser = out_status;

  // The count stays within the capacity.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CAP_C)
    else $error("count exceeds capacity");

  // Every accepted word produces a result in the next cycle.
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    s_acc |=> m_tvalid)
    else $error("accepted word gave no result");

  // A rejected operation leaves the count alone.
  a_reject_holds : assert property (@(posedge clk) disable iff (rst)
    (s_acc && status_next != ST_OK) |=> count == $past(count))
    else $error("count changed on a rejected operation");

  // The top cell is empty unless the list is full.
  a_top_clear : assert property (@(posedge clk) disable iff (rst)
    (CMP_W'(count) < CAP_C) |-> entries[CAPACITY-1] == '0)
    else $error("slot beyond the count is not zero");

endmodule

FILE: sim/tb_indexed_insert_erase_array.sv
`timescale 1ns / 100ps
// Testbench for indexed_insert_erase_array: directed and random list operations,
// checked word by word against a behavioural list kept in the bench.
// Depends on iiea_pkg and the block's RTL only.
module tb_indexed_insert_erase_array;
  import iiea_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;

  // The one operation code the block does not use; it must leave the list alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One expected result, one field per member.
  typedef struct packed {
    logic [WORD_W-1:0]        read_value;
    logic [COUNT_FIELD_W-1:0] element_count;
    logic [ST_W-1:0]          status;
  } list_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;  // index[4:0], value[36:5], zero fill above
  logic [1:0]  s_tuser  = '0;  // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // read_value[31:0], element_count[36:32], zero fill
  logic [1:0]  m_tuser;        // status[1:0]

  // Shadow of the list as the block should hold it after every accepted word.
  logic [WORD_W-1:0] list_words [LIST_CAP] = '{default: '0};
  int                list_len             = 0;

  list_result_t list_results_due [$];
  list_result_t oldest_due;
  int           error_count = 0;

  // Idling odds in percent for each side, and the receiver's long hold-off.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int stall_request = 0;
  int stall_left    = 0;

  indexed_insert_erase_array dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Applies one list operation to the shadow list and returns what the block
  // should report for it. A full list outranks a bad index on insert, and an
  // empty list outranks a bad index on erase.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [WORD_W-1:0] val);
    list_result_t res;
    int           pos;
    res = '0;
    res.status = ST_OK;
    pos = int'(idx);
    case (op)
      OP_INSERT: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (pos > list_len) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = val;
          list_len++;
        end
      end
      OP_ERASE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          list_words[list_len] = '0;
        end
      end
      OP_READ: begin
        if (pos >= list_len) res.status = ST_BAD_INDEX;
        else res.read_value = list_words[pos];
      end
      default: ;
    endcase
    res.element_count = COUNT_FIELD_W'(list_len);
    return res;
  endfunction

  task automatic report_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Scoreboard: every accepted input word adds one expectation, every accepted
  // output word is held against the oldest one. An output word is registered,
  // so it never belongs to the input word accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (list_results_due.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          oldest_due = list_results_due.pop_front();
          report_field("read_value", oldest_due.read_value, m_tdata[31:0]);
          report_field("element_count", 32'(oldest_due.element_count), 32'(m_tdata[36:32]));
          report_field("status", 32'(oldest_due.status), 32'(m_tuser));
          report_field("tdata fill", 32'd0, 32'(m_tdata[39:37]));
        end
      end
      if (s_tvalid && s_tready)
        list_results_due.push_back(apply_list_op(s_tuser, s_tdata[4:0], s_tdata[36:5]));
    end
  end

  // Receiver. A hold-off request is taken over into a cycle count of its own,
  // during which tready stays low whatever the idling odds say.
  always @(posedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Offers one word, after a random run of idle cycles, and returns at the edge
  // at which it is taken. With no gap, tvalid simply stays high.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [WORD_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, val, idx};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // The sender falls silent until every expected word has come back.
  task automatic wait_results_drained;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (list_results_due.size() != 0) @(posedge clk);
  endtask

  // Reads and erases on an empty list, an insert beyond the end, and the
  // unused operation code with every index and value bit set.
  task automatic test_empty_list;
    send_word(OP_READ, 5'd0, 32'h0000_0000);
    send_word(OP_ERASE, 5'd0, 32'hffff_ffff);
    send_word(OP_ERASE, 5'd31, 32'h0000_0000);
    send_word(OP_INSERT, 5'd1, 32'h1234_5678);
    send_word(OP_UNUSED, 5'd31, 32'hffff_ffff);
  endtask

  // Fills the list to capacity through pushes at the front, the back and the
  // middle, then tries one more insert with a bad index: full must win.
  task automatic test_fill_to_full;
    send_word(OP_INSERT, 5'd0, 32'h8000_0000);
    send_word(OP_INSERT, 5'd1, 32'h7fff_ffff);
    send_word(OP_INSERT, 5'd0, 32'hffff_ffff);
    send_word(OP_INSERT, 5'd1, 32'h0000_0001);
    for (int k = 4; k < LIST_CAP; k++)
      send_word(OP_INSERT, INDEX_W'((k * 5) % (k + 1)), 32'ha5a5_0000 | 32'(k));
    send_word(OP_INSERT, 5'd31, 32'hdead_beef);
  endtask

  // Reads at the last slot and just past it, then pops at the back and front.
  task automatic test_list_edges;
    send_word(OP_READ, INDEX_W'(LIST_CAP - 1), 32'h0000_0000);
    send_word(OP_READ, INDEX_W'(LIST_CAP), 32'h0000_0000);
    send_word(OP_ERASE, INDEX_W'(LIST_CAP), 32'h0000_0000);
    send_word(OP_ERASE, INDEX_W'(LIST_CAP - 1), 32'h0000_0000);
    send_word(OP_ERASE, 5'd0, 32'h0000_0000);
  endtask

  // Random operations. The mix leans towards inserts or erases in turn so that
  // the list sweeps between empty and full; most indexes are in range for the
  // current length, a tenth are anywhere in the field.
  task automatic test_random_ops(input int n_words);
    int             fill_len;
    bit             growing;
    int             pick;
    logic [OP_W-1:0]    op;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  val;
    fill_len = list_len;
    growing  = 1'b1;
    repeat (n_words) begin
      if (fill_len == LIST_CAP) growing = 1'b0;
      else if (fill_len == 0) growing = 1'b1;
      else if ($urandom_range(49) == 0) growing = !growing;
      pick = $urandom_range(99);
      if (pick < 4) op = OP_UNUSED;
      else if (pick < 22) op = OP_READ;
      else if (pick < (growing ? 74 : 39)) op = OP_INSERT;
      else op = OP_ERASE;
      if ($urandom_range(9) == 0) idx = INDEX_W'($urandom_range(31));
      else if (op == OP_INSERT) idx = INDEX_W'($urandom_range(fill_len));
      else idx = (fill_len == 0) ? '0 : INDEX_W'($urandom_range(fill_len - 1));
      case ($urandom_range(9))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'hffff_ffff;
        3: val = 32'h0000_0000;
        default: val = $urandom;
      endcase
      send_word(op, idx, val);
      if (op == OP_INSERT && fill_len < LIST_CAP && int'(idx) <= fill_len) fill_len++;
      else if (op == OP_ERASE && fill_len > 0 && int'(idx) < fill_len) fill_len--;
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // words back to back, so the output register fills and tready drops.
  task automatic test_output_stall;
    src_idle_pct  = 0;
    stall_request = 80;
    test_random_ops(40);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 22;
    sink_idle_pct = 88;
    test_empty_list();
    test_fill_to_full();
    test_list_edges();
    wait_results_drained();
    test_random_ops(600);
    wait_results_drained();

    src_idle_pct  = 88;
    sink_idle_pct = 22;
    test_random_ops(600);
    wait_results_drained();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_output_stall();
    wait_results_drained();
    test_random_ops(620);
    wait_results_drained();

    // A stray late word would still be caught by the scoreboard here.
    repeat (8) @(posedge clk);
    if (error_count == 0 && list_results_due.size() == 0) begin
      $display("PASS indexed_insert_erase_array");
    end else begin
      $display("FAIL indexed_insert_erase_array");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAIL indexed_insert_erase_array");
    $finish;
  end

endmodule
